// File: sv/qrgp_pkg.sv
// ----------------------------------------------------------------------------
// qrgp_pkg
// Shared types, constants and arithmetic helpers for quaternion rotation
// with gnomonic projection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qrgp_pkg;

    localparam int FRAC_BITS = 30;
    localparam int OUT_FRAC  = 24;
    localparam int INT_BITS  = 31 - OUT_FRAC;
    localparam int Q_W       = 31;
    localparam int PROD_W    = 64 - FRAC_BITS;
    localparam int SUM_W     = PROD_W + 2;
    localparam int ENT_W     = PROD_W + 3;
    localparam int DIV_STEPS = Q_W;
    localparam int STEP_PER  = 2;
    localparam int DIV_STG   = (DIV_STEPS + STEP_PER - 1) / STEP_PER;
    localparam int ADDR_W    = 4;

    typedef enum logic [1:0] {
        REG_W = 2'd0,
        REG_I = 2'd1,
        REG_J = 2'd2,
        REG_K = 2'd3
    } t_reg_idx;

    typedef logic signed [31:0] t_s32;
    typedef t_s32 t_mat [9];
    typedef logic signed [SUM_W-1:0] t_sum;

    typedef struct packed {
        logic [SUM_W-1:0]    rem;
        logic [Q_W-1:0]      q;
        logic [INT_BITS-1:0] lo;
        logic                neg;
        logic                nsign;
        logic                sat;
    } t_lane;

    function automatic logic signed [PROD_W-1:0] qmul(input t_s32 a, input t_s32 b);
        logic signed [63:0] p;
        p = a * b;
        return p[63:FRAC_BITS];
    endfunction

    function automatic t_s32 sat32(input logic signed [ENT_W-1:0] v);
        logic signed [ENT_W-1:0] hi;
        logic signed [ENT_W-1:0] lo;
        hi = $signed({{(ENT_W-31){1'b0}}, {31{1'b1}}});
        lo = $signed({{(ENT_W-31){1'b1}}, {31{1'b0}}});
        if (v > hi) begin
            return 32'sh7fffffff;
        end else if (v < lo) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic [SUM_W-1:0] mag(input t_sum v);
        return v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
    endfunction

    function automatic t_lane div_step(input t_lane l, input logic [SUM_W-1:0] ad);
        logic [SUM_W:0] trial;
        t_lane          r;
        r     = l;
        trial = {l.rem, l.lo[INT_BITS-1]};
        r.lo  = l.lo << 1;
        if (trial >= {1'b0, ad}) begin
            r.rem = SUM_W'(trial - {1'b0, ad});
            r.q   = {l.q[Q_W-2:0], 1'b1};
        end else begin
            r.rem = trial[SUM_W-1:0];
            r.q   = {l.q[Q_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic t_s32 fmt(input t_lane l, input logic zero);
        if (zero) begin
            return l.nsign ? 32'sh80000000 : 32'sh7fffffff;
        end else if (l.sat) begin
            return l.neg ? 32'sh80000000 : 32'sh7fffffff;
        end
        return l.neg ? -$signed({1'b0, l.q}) : $signed({1'b0, l.q});
    endfunction

endpackage

`default_nettype wire

// File: sv/qrgp_matrix.sv
// ----------------------------------------------------------------------------
// qrgp_matrix
// Builds the rotation matrix from the quaternion registers in two
// register stages: component products, then entry sums with saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qrgp_matrix
    import qrgp_pkg::*;
(
    input  wire logic i_clk,
    input  wire t_s32 i_qw,
    input  wire t_s32 i_qi,
    input  wire t_s32 i_qj,
    input  wire t_s32 i_qk,
    output t_mat      o_mat
);

    logic signed [PROD_W-1:0] r_ww, r_aa, r_bb, r_cc, r_ab, r_ac, r_bc, r_wa, r_wb, r_wc;
    t_mat r_mat;

    always_ff @(posedge i_clk) begin
        r_ww <= qmul(i_qw, i_qw);
        r_aa <= qmul(i_qi, i_qi);
        r_bb <= qmul(i_qj, i_qj);
        r_cc <= qmul(i_qk, i_qk);
        r_ab <= qmul(i_qi, i_qj);
        r_ac <= qmul(i_qi, i_qk);
        r_bc <= qmul(i_qj, i_qk);
        r_wa <= qmul(i_qw, i_qi);
        r_wb <= qmul(i_qw, i_qj);
        r_wc <= qmul(i_qw, i_qk);
    end

    function automatic logic signed [ENT_W-1:0] ext(input logic signed [PROD_W-1:0] v);
        return ENT_W'(v);
    endfunction

    always_ff @(posedge i_clk) begin
        r_mat[0] <= sat32(ext(r_ww) + ext(r_aa) - ext(r_bb) - ext(r_cc));
        r_mat[1] <= sat32((ext(r_ab) - ext(r_wc)) <<< 1);
        r_mat[2] <= sat32((ext(r_ac) + ext(r_wb)) <<< 1);
        r_mat[3] <= sat32((ext(r_ab) + ext(r_wc)) <<< 1);
        r_mat[4] <= sat32(ext(r_ww) - ext(r_aa) + ext(r_bb) - ext(r_cc));
        r_mat[5] <= sat32((ext(r_bc) - ext(r_wa)) <<< 1);
        r_mat[6] <= sat32((ext(r_ac) - ext(r_wb)) <<< 1);
        r_mat[7] <= sat32((ext(r_bc) + ext(r_wa)) <<< 1);
        r_mat[8] <= sat32(ext(r_ww) - ext(r_aa) - ext(r_bb) + ext(r_cc));
    end

    assign o_mat = r_mat;

endmodule

`default_nettype wire

// File: sv/qrgp_rotate.sv
// ----------------------------------------------------------------------------
// qrgp_rotate
// Matrix-vector product: nine products in one stage, three row sums in
// the next.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qrgp_rotate
    import qrgp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_valid,
    input  wire t_mat i_mat,
    input  wire t_s32 i_px,
    input  wire t_s32 i_py,
    input  wire t_s32 i_pz,
    output logic      o_valid,
    output t_sum      o_rx,
    output t_sum      o_ry,
    output t_sum      o_rz
);

    logic signed [PROD_W-1:0] r_p [9];
    logic r_v1, r_v2;
    t_sum r_rx, r_ry, r_rz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                r_p[3*r]   <= qmul(i_mat[3*r],   i_px);
                r_p[3*r+1] <= qmul(i_mat[3*r+1], i_py);
                r_p[3*r+2] <= qmul(i_mat[3*r+2], i_pz);
            end
            r_rx <= SUM_W'(r_p[0]) + SUM_W'(r_p[1]) + SUM_W'(r_p[2]);
            r_ry <= SUM_W'(r_p[3]) + SUM_W'(r_p[4]) + SUM_W'(r_p[5]);
            r_rz <= SUM_W'(r_p[6]) + SUM_W'(r_p[7]) + SUM_W'(r_p[8]);
        end
    end

    assign o_valid = r_v2;
    assign o_rx    = r_rx;
    assign o_ry    = r_ry;
    assign o_rz    = r_rz;

endmodule

`default_nettype wire

// File: sv/qrgp_div.sv
// ----------------------------------------------------------------------------
// qrgp_div
// Pipelined restoring divider for both plane coordinates over one shared
// denominator, two quotient bits per stage (last: one), with range saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qrgp_div
    import qrgp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_valid,
    input  wire t_sum i_rx,
    input  wire t_sum i_ry,
    input  wire t_sum i_rz,
    output logic      o_valid,
    output t_s32      o_u,
    output t_s32      o_v,
    output logic      o_flag
);

    t_lane            r_lu   [DIV_STG+1];
    t_lane            r_lv   [DIV_STG+1];
    logic [SUM_W-1:0] r_ad   [DIV_STG+1];
    logic             r_zero [DIV_STG+1];
    logic             r_vld  [DIV_STG+1];

    logic [SUM_W-1:0] w_ad;
    t_lane            n_lu0, n_lv0;

    function automatic t_lane lane_init(input t_sum num, input logic [SUM_W-1:0] ad,
                                        input logic dsign);
        t_lane            l;
        logic [SUM_W-1:0] an;
        an      = mag(num);
        l.rem   = an >> INT_BITS;
        l.lo    = an[INT_BITS-1:0];
        l.q     = '0;
        l.nsign = num[SUM_W-1];
        l.neg   = num[SUM_W-1] ^ dsign;
        l.sat   = (an >> INT_BITS) >= ad;
        return l;
    endfunction

    always_comb begin
        w_ad  = mag(i_rz);
        n_lu0 = lane_init(i_rx, w_ad, i_rz[SUM_W-1]);
        n_lv0 = lane_init(i_ry, w_ad, i_rz[SUM_W-1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lu[0]   <= n_lu0;
            r_lv[0]   <= n_lv0;
            r_ad[0]   <= w_ad;
            r_zero[0] <= (w_ad == '0);
        end
    end

    for (genvar s = 0; s < DIV_STG; s++) begin : g_stg
        t_lane n_lu, n_lv;

        always_comb begin
            n_lu = r_lu[s];
            n_lv = r_lv[s];
            for (int k = 0; k < STEP_PER; k++) begin
                if (s * STEP_PER + k < DIV_STEPS) begin
                    n_lu = div_step(n_lu, r_ad[s]);
                    n_lv = div_step(n_lv, r_ad[s]);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= r_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_lu[s+1]   <= n_lu;
                r_lv[s+1]   <= n_lv;
                r_ad[s+1]   <= r_ad[s];
                r_zero[s+1] <= r_zero[s];
            end
        end
    end

    assign o_valid = r_vld[DIV_STG];
    assign o_u     = fmt(r_lu[DIV_STG], r_zero[DIV_STG]);
    assign o_v     = fmt(r_lv[DIV_STG], r_zero[DIV_STG]);
    assign o_flag  = r_zero[DIV_STG] | r_lu[DIV_STG].sat | r_lv[DIV_STG].sat;

endmodule

`default_nettype wire

// File: sv/quaternion_rotate_gnomonic_project_top.sv
// ----------------------------------------------------------------------------
// quaternion_rotate_gnomonic_project_top
// Rotates a point by the configured quaternion and projects it onto the
// tangent plane as x/z, y/z in Q8.24 with saturation.
//
//   channel  direction  handshake                       payload
//   point    in         i_point_valid / o_point_ready   i_point_x, i_point_y, i_point_z
//   plane    out        o_plane_valid / i_plane_ready   o_plane_u, o_plane_v, o_range_flag
//   config   in         psel/penable/pwrite, pready     paddr, pwdata, prdata
//
// One beat per cycle while the output is not stalled and the matrix is not settling.
// Stages: 2 rotate, 1 divider entry, 16 divider (two quotient bits each, one in the
// last) and 1 output register. A register write, and reset, hold o_point_ready low
// while the rotation matrix is rebuilt. Reset is synchronous and clears all valid
// bits. A stall at the output freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module quaternion_rotate_gnomonic_project_top
    import qrgp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  wire logic              i_point_valid,
    output logic                   o_point_ready,
    input  wire logic signed [31:0] i_point_x,
    input  wire logic signed [31:0] i_point_y,
    input  wire logic signed [31:0] i_point_z,
    output logic                   o_plane_valid,
    input  wire logic              i_plane_ready,
    output logic signed [31:0]     o_plane_u,
    output logic signed [31:0]     o_plane_v,
    output logic                   o_range_flag
);

    t_s32       r_qw, r_qi, r_qj, r_qk;
    logic [1:0] r_settle;
    logic       w_wr, w_en, w_acc;
    t_reg_idx   w_idx;
    t_mat       w_mat;
    logic       w_rot_v, w_div_v, w_flag;
    t_sum       w_rx, w_ry, w_rz;
    t_s32       w_u, w_v;
    logic       r_out_v, r_flag;
    t_s32       r_u, r_v;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qw     <= 32'sh40000000;
            r_qi     <= '0;
            r_qj     <= '0;
            r_qk     <= '0;
            r_settle <= 2'd2;
        end else begin
            if (w_wr) begin
                r_settle <= 2'd2;
                case (w_idx)
                    REG_W:   r_qw <= pwdata;
                    REG_I:   r_qi <= pwdata;
                    REG_J:   r_qj <= pwdata;
                    REG_K:   r_qk <= pwdata;
                    default: r_qw <= r_qw;
                endcase
            end else if (r_settle != '0) begin
                r_settle <= r_settle - 2'd1;
            end
        end
    end

    always_comb begin
        case (w_idx)
            REG_W:   prdata = r_qw;
            REG_I:   prdata = r_qi;
            REG_J:   prdata = r_qj;
            REG_K:   prdata = r_qk;
            default: prdata = '0;
        endcase
    end

    assign w_en          = !r_out_v || i_plane_ready;
    assign o_point_ready = w_en && (r_settle == '0);
    assign w_acc         = i_point_valid && o_point_ready;

    qrgp_matrix u_matrix (
        .i_clk (i_clk),
        .i_qw  (r_qw),
        .i_qi  (r_qi),
        .i_qj  (r_qj),
        .i_qk  (r_qk),
        .o_mat (w_mat)
    );

    qrgp_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_acc),
        .i_mat   (w_mat),
        .i_px    (i_point_x),
        .i_py    (i_point_y),
        .i_pz    (i_point_z),
        .o_valid (w_rot_v),
        .o_rx    (w_rx),
        .o_ry    (w_ry),
        .o_rz    (w_rz)
    );

    qrgp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_rot_v),
        .i_rx    (w_rx),
        .i_ry    (w_ry),
        .i_rz    (w_rz),
        .o_valid (w_div_v),
        .o_u     (w_u),
        .o_v     (w_v),
        .o_flag  (w_flag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_div_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_u    <= w_u;
            r_v    <= w_v;
            r_flag <= w_flag;
        end
    end

    assign o_plane_valid = r_out_v;
    assign o_plane_u     = r_u;
    assign o_plane_v     = r_v;
    assign o_range_flag  = r_flag;

    a_settle_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_settle != '0) |-> !o_point_ready)
        else $error("point accepted while matrix settles");

    a_write_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |=> !o_point_ready)
        else $error("point accepted right after register write");

    a_u_unflagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_plane_valid && !o_range_flag) |-> (o_plane_u != 32'sh80000000))
        else $error("unflagged u at negative limit");

    a_v_unflagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_plane_valid && !o_range_flag) |-> (o_plane_v != 32'sh80000000))
        else $error("unflagged v at negative limit");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_plane_valid)
        else $error("output valid after reset");

endmodule

`default_nettype wire
